/* src/lppd_pkg.sv */
// Shared constants and types for the lidar point packet deframer.
// No dependencies; imported by lidar_point_packet_deframer, its checker and testbench.
package lppd_pkg;

  // Default sizing of the body walk
  localparam int LPPD_MAX_LASERS        = 32;
  localparam int LPPD_MAX_ELEMENT_BYTES = 4;

  // Configuration register indexes
  localparam logic [1:0] CFG_IDX_LASERS    = 2'd0;
  localparam logic [1:0] CFG_IDX_ELEM      = 2'd1;
  localparam logic [1:0] CFG_IDX_DUAL      = 2'd2;

  // Configuration reset values
  localparam logic [5:0] LASERS_RST        = 6'd32;
  localparam logic [2:0] ELEM_BYTES_RST    = 3'd3;

  // Header and trailer constants
  localparam logic [7:0] START_HI          = 8'hEE;
  localparam logic [7:0] START_LO          = 8'hFF;
  localparam logic [7:0] VERSION_MAJOR     = 8'h06;
  localparam logic [7:0] BLOCK_COUNT       = 8'h08;
  localparam logic [7:0] DIST_UNIT         = 8'h04;
  localparam logic [7:0] DUAL_THRESHOLD    = 8'h39;
  localparam logic [10:0] LEN_SINGLE       = 11'd568;
  localparam logic [10:0] LEN_DUAL         = 11'd1080;
  localparam logic [10:0] POS_MAX          = 11'd2047;
  localparam logic [2:0] LAST_BLOCK        = 3'd7;

  // Status codes
  localparam logic [2:0] ST_OK             = 3'd0;
  localparam logic [2:0] ST_SIZE           = 3'd1;
  localparam logic [2:0] ST_START          = 3'd2;
  localparam logic [2:0] ST_VERSION        = 3'd3;
  localparam logic [2:0] ST_LASERS         = 3'd4;
  localparam logic [2:0] ST_BLOCKS         = 3'd5;
  localparam logic [2:0] ST_UNIT           = 3'd6;
  localparam logic [2:0] ST_RETURN         = 3'd7;

  // Result kinds (tuser)
  localparam logic RK_POINT                = 1'b0;
  localparam logic RK_STATUS               = 1'b1;

  // One output buffer entry: results caused by one input byte
  typedef struct packed {
    logic        pt_vld;
    logic        st_vld;
    logic [2:0]  blk;
    logic [4:0]  las;
    logic [15:0] az;
    logic [31:0] pay;
    logic [2:0]  code;
    logic [47:0] date;
    logic [31:0] micro;
  } res_ent_t;

endpackage

/* src/lidar_point_packet_deframer.sv */
// Lidar point packet deframer: parses a byte stream datagram into point
// and status results. Depends on lppd_pkg.
//
//  channel | dir | tdata                                   | tuser / tlast
//  --------+-----+-----------------------------------------+--------------------
//  in_     | in  | [7:0] data_byte                         | tlast end_of_datagram
//  out_    | out | blk, laser, azimuth, payload, status,   | tuser result_kind
//          |     | date/time, microseconds (see port)      |
//  cfg_    | in  | cfg_index selects register, cfg_data    | -
//
// One byte is parsed per cycle while in_tready is high, in a single registered
// pass; a byte that gives a point is written into the output buffer on its transfer.
// The final byte may give a point and a status: the two-entry output buffer
// then takes two output transfers for that byte.
// in_tready drops only when both buffer entries are occupied.
// rst_n is synchronous; all registers but the buffer payload return to their reset
// values, parse state to the header phase.
module lidar_point_packet_deframer
  import lppd_pkg::*;
#(
  parameter int MAX_LASERS        = LPPD_MAX_LASERS,
  parameter int MAX_ELEMENT_BYTES = LPPD_MAX_ELEMENT_BYTES
) (
  input  logic         clk,
  input  logic         rst_n,
  // input byte stream
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_datagram
  // result stream
  output logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] block_number, [7:3] laser_number, [23:8] block_azimuth,
  // [55:24] element_payload, [58:56] status_code, [106:59] raw_date_time,
  // [138:107] microseconds, [143:139] zero
  output logic [143:0] out_tdata,
  output logic         out_tuser,  // result_kind
  // configuration writes
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  localparam int LW = (MAX_LASERS > 1) ? $clog2(MAX_LASERS) : 1;
  localparam logic [6:0] NL_MAX = 7'(MAX_LASERS);
  localparam logic [3:0] NE_MAX = 4'(MAX_ELEMENT_BYTES);

  // Parse phases
  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_AZIM   = 3'd1;
  localparam logic [2:0] PH_ELEM   = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_RETURN = 3'd4;
  localparam logic [2:0] PH_DATE   = 3'd5;
  localparam logic [2:0] PH_MICRO  = 3'd6;
  localparam logic [2:0] PH_DONE   = 3'd7;

  // Configuration registers
  logic [5:0] lasers_r;
  logic [2:0] elem_bytes_r;
  logic       dual_r;

  // Parse state
  logic [10:0]   pos_r, pos_nxt;
  logic [2:0]    phase_r, phase_nxt;
  logic [2:0]    blk_r, blk_nxt;
  logic [LW-1:0] las_r, las_nxt;
  logic [3:0]    fbc_r, fbc_nxt;
  logic [15:0]   az_r, az_nxt;
  logic [31:0]   shift_r, shift_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [47:0]   date_r, date_nxt;
  logic [31:0]   micro_r, micro_nxt;

  // Output buffer
  res_ent_t   buf_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       pt_done_r;

  res_ent_t   ent_nxt;
  logic       in_xfer, out_xfer, push, pop;
  logic [6:0] nl;
  logic [3:0] ne;
  logic [7:0] b;
  logic [31:0] cur_shift;
  logic [2:0] code;
  res_ent_t   head;
  logic       show_point;

  assign cfg_ready = 1'b1;
  assign b         = in_tdata;
  assign in_tready = (cnt_r != 2'd2);
  assign in_xfer   = in_tvalid && in_tready;

  // Saturated walk sizes
  always_comb begin
    if (lasers_r == 6'd0)               nl = 7'd1;
    else if ({1'b0, lasers_r} > NL_MAX) nl = NL_MAX;
    else                                nl = {1'b0, lasers_r};
    if (elem_bytes_r == 3'd0)               ne = 4'd1;
    else if ({1'b0, elem_bytes_r} > NE_MAX) ne = NE_MAX;
    else                                    ne = {1'b0, elem_bytes_r};
  end

  // Element bytes merged with the current byte
  always_comb begin
    cur_shift = shift_r;
    if (fbc_r < 4'd4) begin
      unique case (fbc_r[1:0])
        2'd0: cur_shift[7:0]   = shift_r[7:0]   | b;
        2'd1: cur_shift[15:8]  = shift_r[15:8]  | b;
        2'd2: cur_shift[23:16] = shift_r[23:16] | b;
        default: cur_shift[31:24] = shift_r[31:24] | b;
      endcase
    end
  end

  // Byte parser
  always_comb begin
    pos_nxt   = pos_r;
    phase_nxt = phase_r;
    blk_nxt   = blk_r;
    las_nxt   = las_r;
    fbc_nxt   = fbc_r;
    az_nxt    = az_r;
    shift_nxt = shift_r;
    err_nxt   = err_r;
    date_nxt  = date_r;
    micro_nxt = micro_r;
    ent_nxt   = '0;

    unique case (phase_r)
      PH_HEADER: begin
        if (err_r == ST_OK) begin
          priority if (pos_r == 11'd0 && b != START_HI)                err_nxt = ST_START;
          else if (pos_r == 11'd1 && b != START_LO)                    err_nxt = ST_START;
          else if (pos_r == 11'd2 && b != VERSION_MAJOR)               err_nxt = ST_VERSION;
          else if (pos_r == 11'd6 && b != {2'b00, lasers_r})           err_nxt = ST_LASERS;
          else if (pos_r == 11'd7 && b != BLOCK_COUNT)                 err_nxt = ST_BLOCKS;
          else if (pos_r == 11'd9 && b != DIST_UNIT)                   err_nxt = ST_UNIT;
          else                                                         err_nxt = err_r;
        end
        if (pos_r >= 11'd11) begin
          phase_nxt = PH_AZIM;
          fbc_nxt   = '0;
        end
      end
      PH_AZIM: begin
        if (fbc_r == 4'd0) begin
          az_nxt  = {8'h00, b};
          fbc_nxt = 4'd1;
        end else begin
          az_nxt    = {b, az_r[7:0]};
          phase_nxt = PH_ELEM;
          fbc_nxt   = '0;
          las_nxt   = '0;
          shift_nxt = '0;
        end
      end
      PH_ELEM: begin
        if (fbc_r < ne) begin
          shift_nxt = cur_shift;
          if (fbc_r + 4'd1 == ne) begin
            ent_nxt.pt_vld = 1'b1;
            ent_nxt.blk    = blk_r;
            ent_nxt.las    = 5'(las_r);
            ent_nxt.az     = az_r;
            ent_nxt.pay    = cur_shift;
          end
          fbc_nxt = fbc_r + 4'd1;
        end else begin
          fbc_nxt   = '0;
          shift_nxt = '0;
          if (7'(las_r) + 7'd1 < nl) begin
            las_nxt = las_r + LW'(1);
          end else begin
            las_nxt = '0;
            if (blk_r < LAST_BLOCK) begin
              blk_nxt   = blk_r + 3'd1;
              phase_nxt = PH_AZIM;
            end else begin
              phase_nxt = PH_SKIP;
            end
          end
        end
      end
      PH_SKIP: begin
        if (fbc_r >= 4'd9) begin
          phase_nxt = PH_RETURN;
          fbc_nxt   = '0;
        end else begin
          fbc_nxt = fbc_r + 4'd1;
        end
      end
      PH_RETURN: begin
        if (fbc_r == 4'd0 && err_r == ST_OK && ((b >= DUAL_THRESHOLD) != dual_r))
          err_nxt = ST_RETURN;
        if (fbc_r >= 4'd2) begin
          phase_nxt = PH_DATE;
          fbc_nxt   = '0;
        end else begin
          fbc_nxt = fbc_r + 4'd1;
        end
      end
      PH_DATE: begin
        date_nxt = {date_r[39:0], b};
        if (fbc_r >= 4'd5) begin
          phase_nxt = PH_MICRO;
          fbc_nxt   = '0;
        end else begin
          fbc_nxt = fbc_r + 4'd1;
        end
      end
      PH_MICRO: begin
        unique case (fbc_r[1:0])
          2'd0: micro_nxt[7:0]   = micro_r[7:0]   | b;
          2'd1: micro_nxt[15:8]  = micro_r[15:8]  | b;
          2'd2: micro_nxt[23:16] = micro_r[23:16] | b;
          default: micro_nxt[31:24] = micro_r[31:24] | b;
        endcase
        if (fbc_r >= 4'd3) begin
          phase_nxt = PH_DONE;
          fbc_nxt   = '0;
        end else begin
          fbc_nxt = fbc_r + 4'd1;
        end
      end
      default: begin
      end
    endcase

    // Saturating byte position
    if (pos_r < POS_MAX) pos_nxt = pos_r + 11'd1;

    // Verdict on the final byte
    if (pos_nxt != LEN_SINGLE && pos_nxt != LEN_DUAL)       code = ST_SIZE;
    else if (err_nxt >= ST_START && err_nxt <= ST_UNIT)     code = err_nxt;
    else if (phase_nxt != PH_DONE)                          code = ST_SIZE;
    else                                                    code = err_nxt;

    if (in_tlast) begin
      ent_nxt.st_vld = 1'b1;
      ent_nxt.code   = code;
      ent_nxt.date   = date_nxt;
      ent_nxt.micro  = micro_nxt;
      pos_nxt   = '0;
      phase_nxt = PH_HEADER;
      blk_nxt   = '0;
      las_nxt   = '0;
      fbc_nxt   = '0;
      az_nxt    = '0;
      shift_nxt = '0;
      err_nxt   = ST_OK;
      date_nxt  = '0;
      micro_nxt = '0;
    end
  end

  // Output side: point first, then status of the same byte
  assign head       = buf_r[rd_ptr_r];
  assign show_point = head.pt_vld && !pt_done_r;
  assign out_tvalid = (cnt_r != 2'd0);
  assign out_xfer   = out_tvalid && out_tready;
  assign pop        = out_xfer && !(show_point && head.st_vld);
  assign push       = in_xfer && (ent_nxt.pt_vld || ent_nxt.st_vld);
  assign out_tuser  = show_point ? RK_POINT : RK_STATUS;

  always_comb begin
    out_tdata = '0;
    if (show_point) begin
      out_tdata[2:0]   = head.blk;
      out_tdata[7:3]   = head.las;
      out_tdata[23:8]  = head.az;
      out_tdata[55:24] = head.pay;
    end else begin
      out_tdata[58:56]   = head.code;
      out_tdata[106:59]  = head.date;
      out_tdata[138:107] = head.micro;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lasers_r     <= LASERS_RST;
      elem_bytes_r <= ELEM_BYTES_RST;
      dual_r       <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_IDX_LASERS: lasers_r     <= cfg_data;
        CFG_IDX_ELEM:   elem_bytes_r <= cfg_data[2:0];
        CFG_IDX_DUAL:   dual_r       <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      phase_r <= PH_HEADER;
      blk_r   <= '0;
      las_r   <= '0;
      fbc_r   <= '0;
      az_r    <= '0;
      shift_r <= '0;
      err_r   <= ST_OK;
      date_r  <= '0;
      micro_r <= '0;
    end else if (in_xfer) begin
      pos_r   <= pos_nxt;
      phase_r <= phase_nxt;
      blk_r   <= blk_nxt;
      las_r   <= las_nxt;
      fbc_r   <= fbc_nxt;
      az_r    <= az_nxt;
      shift_r <= shift_nxt;
      err_r   <= err_nxt;
      date_r  <= date_nxt;
      micro_r <= micro_nxt;
    end
  end

  // Buffer payload
  always_ff @(posedge clk) begin
    if (push) buf_r[wr_ptr_r] <= ent_nxt;
  end

  // Buffer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      cnt_r     <= 2'd0;
      pt_done_r <= 1'b0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
      if (pop)           pt_done_r <= 1'b0;
      else if (out_xfer) pt_done_r <= 1'b1;
    end
  end

endmodule

/* tb/lidar_point_packet_deframer_checker.sv */
`timescale 1ns / 100ps
// Checker for lidar_point_packet_deframer: mirrors config writes, parses each
// accepted byte with its own datagram parser and compares every result transfer.
// Depends on lppd_pkg.
module lidar_point_packet_deframer_checker
  import lppd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [7:0]   in_tdata,   // [7:0] data_byte
  input  logic         in_tlast,   // end_of_datagram
  input  logic         out_tvalid,
  input  logic         out_tready,
  // [2:0] block, [7:3] laser, [23:8] azimuth, [55:24] payload, [58:56] status,
  // [106:59] date/time, [138:107] microseconds
  input  logic [143:0] out_tdata,
  input  logic         out_tuser,  // result_kind
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [5:0]   cfg_data,
  output int           fail_count,
  output int           results_due
);

  typedef enum logic [2:0] {
    STG_HEADER, STG_AZIMUTH, STG_POINTS, STG_RESERVED,
    STG_RETURN, STG_DATE, STG_MICRO, STG_IDLE
  } parse_stage_e;

  typedef struct packed {
    logic        kind;
    logic [2:0]  blk;
    logic [4:0]  las;
    logic [15:0] az;
    logic [31:0] pay;
    logic [2:0]  code;
    logic [47:0] date;
    logic [31:0] micro;
  } deframed_result_t;

  deframed_result_t expected_results[$];

  // mirrored configuration
  logic [5:0] lasers_reg;
  logic [2:0] elem_reg;
  logic       dual_reg;

  // parser state
  logic [10:0]  byte_pos;
  parse_stage_e stage;
  logic [2:0]   blk_cnt;
  logic [4:0]   las_cnt;
  logic [3:0]   fld_cnt;
  logic [15:0]  az_hold;
  logic [31:0]  elem_acc;
  logic [2:0]   first_err;
  logic [47:0]  date_hold;
  logic [31:0]  micro_hold;

  function automatic void clear_parse();
    byte_pos   = '0;
    stage      = STG_HEADER;
    blk_cnt    = '0;
    las_cnt    = '0;
    fld_cnt    = '0;
    az_hold    = '0;
    elem_acc   = '0;
    first_err  = ST_OK;
    date_hold  = '0;
    micro_hold = '0;
  endfunction

  // only the first error of a datagram is kept
  function automatic void note_error(logic [2:0] code);
    if (first_err == ST_OK) first_err = code;
  endfunction

  function automatic void check_header(logic [10:0] pos, logic [7:0] b);
    if (pos == 0 && b != START_HI) note_error(ST_START);
    if (pos == 1 && b != START_LO) note_error(ST_START);
    if (pos == 2 && b != VERSION_MAJOR) note_error(ST_VERSION);
    if (pos == 6 && b != {2'b00, lasers_reg}) note_error(ST_LASERS);
    if (pos == 7 && b != BLOCK_COUNT) note_error(ST_BLOCKS);
    if (pos == 9 && b != DIST_UNIT) note_error(ST_UNIT);
  endfunction

  // Advance the parser by one byte and queue the results it gives
  function automatic void predict_byte(logic [7:0] b, logic last);
    deframed_result_t r;
    int nl;
    int ne;
    logic [10:0] pos;
    pos = byte_pos;
    // body walk uses the registers clamped to the supported range
    nl = (lasers_reg < 1) ? 1 : ((lasers_reg > LPPD_MAX_LASERS) ? LPPD_MAX_LASERS
                                                                : int'(lasers_reg));
    ne = (elem_reg < 1) ? 1 :
         ((elem_reg > LPPD_MAX_ELEMENT_BYTES) ? LPPD_MAX_ELEMENT_BYTES : int'(elem_reg));
    case (stage)
      STG_HEADER: begin
        check_header(pos, b);
        if (pos >= 11) begin
          stage   = STG_AZIMUTH;
          fld_cnt = '0;
        end
      end
      STG_AZIMUTH: begin
        if (fld_cnt == 0) begin
          az_hold = {8'h00, b};
          fld_cnt = 4'd1;
        end else begin
          az_hold[15:8] = b;
          stage    = STG_POINTS;
          fld_cnt  = '0;
          las_cnt  = '0;
          elem_acc = '0;
        end
      end
      STG_POINTS: begin
        if (fld_cnt < ne) begin
          if (fld_cnt < 4) elem_acc |= 32'(b) << (8 * fld_cnt);
          // point leaves on the last payload byte of the element
          if (fld_cnt + 1 == ne) begin
            r      = '0;
            r.kind = RK_POINT;
            r.blk  = blk_cnt;
            r.las  = las_cnt;
            r.az   = az_hold;
            r.pay  = elem_acc;
            expected_results.push_back(r);
          end
          fld_cnt++;
        end else begin
          // reserved byte closes the element
          fld_cnt  = '0;
          elem_acc = '0;
          if (las_cnt + 1 < nl) begin
            las_cnt++;
          end else begin
            las_cnt = '0;
            if (blk_cnt < LAST_BLOCK) begin
              blk_cnt++;
              stage = STG_AZIMUTH;
            end else begin
              stage = STG_RESERVED;
            end
          end
        end
      end
      STG_RESERVED: begin
        if (fld_cnt >= 9) begin
          stage   = STG_RETURN;
          fld_cnt = '0;
        end else begin
          fld_cnt++;
        end
      end
      STG_RETURN: begin
        // return-mode byte, then two motor-speed bytes
        if (fld_cnt == 0 && ((b >= DUAL_THRESHOLD) != dual_reg)) note_error(ST_RETURN);
        if (fld_cnt >= 2) begin
          stage   = STG_DATE;
          fld_cnt = '0;
        end else begin
          fld_cnt++;
        end
      end
      STG_DATE: begin
        date_hold = {date_hold[39:0], b};
        if (fld_cnt >= 5) begin
          stage   = STG_MICRO;
          fld_cnt = '0;
        end else begin
          fld_cnt++;
        end
      end
      STG_MICRO: begin
        micro_hold |= 32'(b) << (8 * fld_cnt[1:0]);
        if (fld_cnt >= 3) begin
          stage   = STG_IDLE;
          fld_cnt = '0;
        end else begin
          fld_cnt++;
        end
      end
      default: ;
    endcase

    if (byte_pos < POS_MAX) byte_pos++;

    // final byte: status after any point it completed
    if (last) begin
      r      = '0;
      r.kind = RK_STATUS;
      if (byte_pos != LEN_SINGLE && byte_pos != LEN_DUAL) r.code = ST_SIZE;
      else if (first_err >= ST_START && first_err <= ST_UNIT) r.code = first_err;
      else if (stage != STG_IDLE) r.code = ST_SIZE;
      else r.code = first_err;
      r.date  = date_hold;
      r.micro = micro_hold;
      expected_results.push_back(r);
      clear_parse();
    end
  endfunction

  function automatic void compare_field(string what, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, what, want, got);
    end
  endfunction

  // Compare one result transfer with the oldest expectation
  function automatic void check_result();
    deframed_result_t want;
    deframed_result_t got;
    got.kind  = out_tuser;
    got.blk   = out_tdata[2:0];
    got.las   = out_tdata[7:3];
    got.az    = out_tdata[23:8];
    got.pay   = out_tdata[55:24];
    got.code  = out_tdata[58:56];
    got.date  = out_tdata[106:59];
    got.micro = out_tdata[138:107];
    if (expected_results.size() == 0) begin
      fail_count++;
      $display("%0t: result transfer with none expected, got kind %0d tdata 0x%0h",
               $time, got.kind, out_tdata);
    end else begin
      want = expected_results.pop_front();
      compare_field("result_kind", want.kind, got.kind);
      compare_field("block_number", want.blk, got.blk);
      compare_field("laser_number", want.las, got.las);
      compare_field("block_azimuth", want.az, got.az);
      compare_field("element_payload", want.pay, got.pay);
      compare_field("status_code", want.code, got.code);
      compare_field("raw_date_time", want.date, got.date);
      compare_field("microseconds", want.micro, got.micro);
    end
  endfunction

  // Watch all channels at the rising edge
  always @(posedge clk) begin
    if (!rst_n) begin
      lasers_reg = LASERS_RST;
      elem_reg   = ELEM_BYTES_RST;
      dual_reg   = 1'b0;
      clear_parse();
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_IDX_LASERS: lasers_reg = cfg_data;
          CFG_IDX_ELEM:   elem_reg   = cfg_data[2:0];
          CFG_IDX_DUAL:   dual_reg   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) predict_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    results_due = expected_results.size();
  end

endmodule

/* tb/lidar_point_packet_deframer_tb.sv */
`timescale 1ns / 100ps
// Testbench top for lidar_point_packet_deframer: writes configurations, sends
// clean and damaged datagrams under varied flow control, and gives the verdict.
// Depends on lppd_pkg, the deframer RTL and lidar_point_packet_deframer_checker.
module lidar_point_packet_deframer_tb;
  import lppd_pkg::*;

  localparam logic [1:0] CFG_IDX_SPARE = 2'd3;  // unmapped index, must be ignored
  localparam int HOLD_CYCLES   = 300;
  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 8;
  localparam int NUM_SETTINGS  = 7;
  localparam int SHORT_ITEMS   = 40;   // minimum cut/noise bytes per setting
  localparam int MAX_CUT       = 120;

  typedef enum int {FLOW_FREE, FLOW_SRC_IDLE, FLOW_SINK_STALL, FLOW_BOTH} flow_mode_e;
  typedef enum int {
    DG_CLEAN, DG_RETURN, DG_HEADER, DG_LENGTH, DG_TRUNC, DG_NOISE
  } dgram_kind_e;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;   // [7:0] data_byte
  logic         in_tlast;   // end_of_datagram
  logic         out_tvalid;
  logic         out_tready;
  // [2:0] block, [7:3] laser, [23:8] azimuth, [55:24] payload, [58:56] status,
  // [106:59] date/time, [138:107] microseconds, [143:139] zero
  logic [143:0] out_tdata;
  logic         out_tuser;  // result_kind
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [5:0]   cfg_data;

  int fail_count;
  int results_due;
  int quiet_cycles;

  flow_mode_e flow;
  int         hold_requests;
  logic [7:0] frame_bytes[$];

  // settings currently in the block, used to build datagrams
  logic [5:0] lasers_cfg;
  logic [2:0] elem_cfg;
  logic       dual_cfg;

  lidar_point_packet_deframer dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  lidar_point_packet_deframer_checker u_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic int src_idle_pct();
    case (flow)
      FLOW_SRC_IDLE: return 83;
      FLOW_BOTH:     return 38;
      default:       return 0;
    endcase
  endfunction

  function automatic int sink_stall_pct();
    case (flow)
      FLOW_SINK_STALL: return 83;
      FLOW_BOTH:       return 38;
      default:         return 0;
    endcase
  endfunction

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin
    int holds_done;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != holds_done) begin
        holds_done++;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= ($urandom_range(0, 99) < sink_stall_pct()) ? 1'b0 : 1'b1;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [5:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // Reconfigure only once the block has drained
  task automatic apply_settings(logic [5:0] lasers, logic [2:0] elem, logic dual);
    in_tvalid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    write_reg(CFG_IDX_LASERS, lasers);
    write_reg(CFG_IDX_ELEM, {3'($urandom), elem});
    write_reg(CFG_IDX_DUAL, {5'($urandom), dual});
    write_reg(CFG_IDX_SPARE, 6'($urandom));
    cfg_valid  <= 1'b0;
    lasers_cfg = lasers;
    elem_cfg   = elem;
    dual_cfg   = dual;
  endtask

  task automatic send_byte(logic [7:0] b, logic last);
    while ($urandom_range(0, 99) < src_idle_pct()) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  function automatic logic [7:0] return_byte(logic dual);
    // boundary values now and then, otherwise anywhere on the matching side
    if ($urandom_range(0, 3) == 0) return dual ? DUAL_THRESHOLD : DUAL_THRESHOLD - 8'd1;
    return dual ? 8'($urandom_range(DUAL_THRESHOLD, 255))
                : 8'($urandom_range(0, DUAL_THRESHOLD - 1));
  endfunction

  // Kind of a full-length datagram
  function automatic dgram_kind_e pick_kind();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return DG_CLEAN;
    if (roll < 40) return DG_RETURN;
    if (roll < 85) return DG_HEADER;
    return DG_LENGTH;
  endfunction

  // Build one datagram for the current settings, damaged as the kind asks
  function automatic void build_frame(dgram_kind_e kind);
    int nl;
    int ne;
    int ret_pos;
    int target;
    int cut;
    bit damaged;
    int hdr_pos[6] = '{0, 1, 2, 6, 7, 9};
    nl = (lasers_cfg < 1) ? 1 : ((lasers_cfg > LPPD_MAX_LASERS) ? LPPD_MAX_LASERS
                                                                : int'(lasers_cfg));
    ne = (elem_cfg < 1) ? 1 :
         ((elem_cfg > LPPD_MAX_ELEMENT_BYTES) ? LPPD_MAX_ELEMENT_BYTES : int'(elem_cfg));
    frame_bytes.delete();
    if (kind == DG_NOISE) begin
      repeat ($urandom_range(1, 40)) frame_bytes.push_back(8'($urandom));
      return;
    end

    // header
    frame_bytes = '{START_HI, START_LO, VERSION_MAJOR, 8'($urandom), 8'($urandom),
                    8'($urandom), {2'b00, lasers_cfg}, BLOCK_COUNT, 8'($urandom),
                    DIST_UNIT, 8'($urandom), 8'($urandom)};
    // blocks: azimuth, then payload plus reserved byte per laser
    for (int blk = 0; blk < 8; blk++) begin
      repeat (2) frame_bytes.push_back(8'($urandom));
      repeat (nl * (ne + 1)) frame_bytes.push_back(8'($urandom));
    end
    // trailer: reserved, return mode, motor speed, date/time, microseconds
    repeat (10) frame_bytes.push_back(8'($urandom));
    ret_pos = frame_bytes.size();
    frame_bytes.push_back(return_byte(dual_cfg));
    repeat (12) frame_bytes.push_back(8'($urandom));

    target = (frame_bytes.size() <= LEN_SINGLE) ? int'(LEN_SINGLE) : int'(LEN_DUAL);
    case (kind)
      DG_LENGTH: begin
        if ($urandom_range(0, 1)) target = target - int'($urandom_range(1, 12));
        else target = target + int'($urandom_range(1, 12));
      end
      DG_RETURN: frame_bytes[ret_pos] = return_byte(!dual_cfg);
      DG_HEADER: begin
        // one or more header fields wrong, sometimes the return mode too
        damaged = 1'b0;
        while (!damaged) begin
          foreach (hdr_pos[k]) begin
            if ($urandom_range(0, 99) < 30) begin
              frame_bytes[hdr_pos[k]] ^= 8'($urandom_range(1, 255));
              damaged = 1'b1;
            end
          end
        end
        if ($urandom_range(0, 99) < 30) frame_bytes[ret_pos] = return_byte(!dual_cfg);
      end
      default: ;
    endcase
    if (kind == DG_TRUNC) begin
      cut    = $urandom_range(1, MAX_CUT);
      target = cut;
    end
    while (frame_bytes.size() < target) frame_bytes.push_back(8'($urandom));
    while (frame_bytes.size() > target) void'(frame_bytes.pop_back());
  endfunction

  // Stimulus
  initial begin
    int items_here;
    int frames_here;
    int dgram_count;
    dgram_kind_e kind;

    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    in_tlast      = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = CFG_IDX_LASERS;
    cfg_data      = '0;
    flow          = FLOW_FREE;
    hold_requests = 0;
    lasers_cfg    = LASERS_RST;
    elem_cfg      = ELEM_BYTES_RST;
    dual_cfg      = 1'b0;
    dgram_count   = 0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-byte datagram, then a two-byte one of zeros
    frame_bytes = '{8'hFF};
    send_frame();
    frame_bytes = '{8'h00, 8'h00};
    send_frame();

    // one laser, one-byte elements: points in two blocks, the last byte
    // completes a point and ends a short datagram
    apply_settings(6'd1, 3'd1, 1'b1);
    frame_bytes = '{START_HI, START_LO, VERSION_MAJOR, 8'h00, 8'hFF, 8'h00, 8'h01,
                    BLOCK_COUNT, 8'hFF, DIST_UNIT, 8'h00, 8'hFF, 8'h34, 8'h12,
                    8'hA5, 8'h5A, 8'hFF, 8'hFF, 8'h00};
    send_frame();

    // cut and noise datagrams over a range of settings, extremes included
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      case (s)
        0: apply_settings(LASERS_RST, ELEM_BYTES_RST, 1'b0);
        1: apply_settings(6'd1, 3'd1, 1'b1);
        2: apply_settings(6'd32, 3'd4, 1'b1);
        3: apply_settings(6'd0, 3'd0, 1'b0);
        4: apply_settings(6'd63, 3'd7, 1'b0);
        5: apply_settings(6'($urandom_range(1, 32)), 3'($urandom_range(1, 4)),
                          1'($urandom));
        default: apply_settings(6'($urandom), 3'($urandom), 1'($urandom));
      endcase
      items_here  = 0;
      frames_here = 0;
      while (items_here < SHORT_ITEMS || frames_here < 2) begin
        flow = flow_mode_e'(dgram_count % 4);
        kind = ($urandom_range(0, 3) != 0) ? DG_TRUNC : DG_NOISE;
        build_frame(kind);
        items_here += frame_bytes.size();
        frames_here++;
        dgram_count++;
        send_frame();
      end
    end

    // full-length datagrams: a clean one from a full-rate sender against a
    // long receiver hold-off, then one of a random kind, mostly with a fault
    apply_settings(6'd2, 3'd2, 1'($urandom));
    flow = FLOW_FREE;
    hold_requests++;
    build_frame(DG_CLEAN);
    send_frame();
    flow = flow_mode_e'($urandom_range(0, 3));
    build_frame(pick_kind());
    send_frame();

    // drain and give the verdict
    in_tvalid <= 1'b0;
    flow = FLOW_FREE;
    while (results_due != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (fail_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

/* sim.f */
src/lppd_pkg.sv
src/lidar_point_packet_deframer.sv
tb/lidar_point_packet_deframer_checker.sv
tb/lidar_point_packet_deframer_tb.sv
